[sv/sha256_byte_stream_hasher_assert.svh]
// Assertion macros for the SHA-256 byte stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SHA_ASSERT(label, prop, msg)
`define SHA_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

[sv/sha_pkg.sv]
// Shared types, constants and functions of the SHA-256 hasher.
package sha_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    typedef enum logic [1:0] {
        BSRC_INPUT = 2'd0,
        BSRC_PAD   = 2'd1,
        BSRC_ZERO  = 2'd2,
        BSRC_LEN   = 2'd3
    } byte_src_t;

    typedef struct packed {
        logic      put_byte;
        byte_src_t src;
        logic      add_len;
        logic      start_block;
        logic      round;
        logic      finish_block;
        logic      out_load;
        logic      out_shift;
        logic      reinit;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] byte_pos;
        logic       last_round;
    } sha_stat_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction
endpackage

[sv/sha_datapath.sv]
// Datapath: byte packing, length counter, schedule, round unit, chaining state, output shifter.
module sha_datapath
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sha_cmd_t    cmd,
    input  logic [7:0]  data_byte,
    output sha_stat_t   stat,
    output logic [31:0] out_word
);
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic [2:0]  lenb_reg, lenb_next;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8], h_next [8];
    logic [31:0] hsum [8];
    logic [31:0] o_reg [8];
    logic [5:0]  rnd_reg, rnd_next;
    logic [7:0]  wbyte;
    logic [31:0] wr, sg0, sg1, t1, t2, bs0, bs1, chs, mj;

    always_comb
    begin
        case (cmd.src)
            BSRC_INPUT: wbyte = data_byte;
            BSRC_PAD:   wbyte = PAD_BYTE;
            BSRC_ZERO:  wbyte = 8'h00;
            BSRC_LEN:   wbyte = len_reg[63 - 8 * lenb_reg -: 8];
            default:    wbyte = 8'h00;
        endcase
    end

    assign sg0 = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign sg1 = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wr  = w_reg[0];
    assign bs1 = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
    assign chs = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1  = v_reg[7] + bs1 + chs + ROUND_K[rnd_reg] + wr;
    assign bs0 = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
    assign mj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2  = bs0 + mj;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            hsum[k] = h_reg[k] + v_reg[k];
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        lenb_next = lenb_reg;
        rnd_next  = rnd_reg;
        for (int k = 0; k < 8; k++)
        begin
            h_next[k] = h_reg[k];
        end
        if (cmd.put_byte)
        begin
            pos_next = pos_reg + 6'd1;
            if (cmd.src == BSRC_LEN)
            begin
                lenb_next = lenb_reg + 3'd1;
            end
        end
        if (cmd.add_len)
        begin
            len_next = len_reg + 64'd8;
        end
        if (cmd.start_block)
        begin
            rnd_next = '0;
        end
        else if (cmd.round)
        begin
            rnd_next = rnd_reg + 6'd1;
        end
        if (cmd.finish_block)
        begin
            for (int k = 0; k < 8; k++)
            begin
                h_next[k] = hsum[k];
            end
        end
        if (cmd.reinit)
        begin
            for (int k = 0; k < 8; k++)
            begin
                h_next[k] = INIT_HASH[k];
            end
            pos_next  = '0;
            len_next  = '0;
            lenb_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            lenb_reg <= '0;
            rnd_reg  <= '0;
            for (int k = 0; k < 8; k++)
            begin
                h_reg[k] <= INIT_HASH[k];
            end
        end
        else
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            lenb_reg <= lenb_next;
            rnd_reg  <= rnd_next;
            for (int k = 0; k < 8; k++)
            begin
                h_reg[k] <= h_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put_byte)
        begin
            w_reg[pos_reg[5:2]][{~pos_reg[1:0], 3'b000} +: 8] <= wbyte;
        end
        if (cmd.start_block)
        begin
            for (int k = 0; k < 8; k++)
            begin
                v_reg[k] <= h_reg[k];
            end
        end
        else if (cmd.round)
        begin
            for (int k = 0; k < 15; k++)
            begin
                w_reg[k] <= w_reg[k + 1];
            end
            w_reg[15] <= w_reg[0] + sg0 + w_reg[9] + sg1;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (cmd.out_load)
        begin
            for (int k = 0; k < 8; k++)
            begin
                o_reg[k] <= hsum[k];
            end
        end
        else if (cmd.out_shift)
        begin
            for (int k = 0; k < 7; k++)
            begin
                o_reg[k] <= o_reg[k + 1];
            end
            o_reg[7] <= o_reg[7];
        end
    end

    assign stat.byte_pos   = pos_reg;
    assign stat.last_round = (rnd_reg == 6'd63);
    assign out_word        = o_reg[0];
endmodule

[sv/sha_ctrl.sv]
// Controller: sequences byte intake, padding, rounds and digest output.
module sha_ctrl
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sha_in_t   in_item,
    input  logic      in_valid,
    output logic      in_ready,
    input  sha_stat_t stat,
    output sha_cmd_t  cmd,
    output logic      out_valid,
    input  logic      out_ready,
    output logic [2:0] out_index
);
    `include "sha256_byte_stream_hasher_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_ROUND, S_FINISH, S_ADD, S_PAD, S_LEN, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;
    logic [2:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    state_t     after_reg, after_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_index = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg;
        after_next = after_reg;
        cmd        = '0;
        cmd.src    = BSRC_INPUT;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.put_byte = in_item.has_byte;
                    cmd.add_len  = in_item.has_byte;
                    fin_next     = in_item.end_of_message;
                    if (in_item.has_byte && stat.byte_pos == 6'd63)
                    begin
                        state_next  = S_ROUND;
                        after_next  = in_item.end_of_message ? S_PAD : S_IDLE;
                    end
                    else if (in_item.end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.start_block = 1'b1;
                state_next      = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.round = 1'b1;
                if (stat.last_round)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (after_reg == S_OUT)
                begin
                    cmd.out_load = 1'b1;
                    cmd.reinit   = 1'b1;
                    ov_next      = 1'b1;
                    idx_next     = '0;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.finish_block = 1'b1;
                    state_next       = after_reg;
                end
            end
            S_PAD:
            begin
                cmd.put_byte = 1'b1;
                cmd.src      = fin_reg ? BSRC_PAD : BSRC_ZERO;
                fin_next     = 1'b0;
                if (stat.byte_pos == 6'd63)
                begin
                    state_next = S_ROUND;
                    after_next = S_PAD;
                end
                else if (stat.byte_pos + 6'd1 == LEN_POS)
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                cmd.put_byte = 1'b1;
                cmd.src      = BSRC_LEN;
                if (stat.byte_pos == 6'd63)
                begin
                    state_next = S_ROUND;
                    after_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (ov_reg && out_ready)
                begin
                    cmd.out_shift = 1'b1;
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        ov_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
            after_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
            after_reg <= after_next;
        end
    end

    `SHA_ASSERT(a_no_accept_busy, !(accept && ov_reg), "item accepted during output")
    `SHA_ASSERT(a_out_in_out_state, !ov_reg || state_reg == S_OUT, "output outside output state")
    `SHA_ASSERT_NEXT(a_round_starts, state_reg == S_ROUND, state_reg == S_FINISH, "round start lost")
endmodule

[sv/sha256_byte_stream_hasher.sv]
// SHA-256 over a byte stream: one byte per item, digest as eight words after the last item.
// Each completed 64-byte block holds the input while the single round unit runs 64 rounds
// plus a state load and a final add. After the last item the block writes padding and
// length one byte per cycle, pausing while a full block is compressed, compresses one or
// two blocks, and then offers the eight digest words, high word first, at up to one per
// cycle. No new item is taken until the eighth word is delivered.
module sha256_byte_stream_hasher
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sha_in_t  in_data,
    input  logic     in_valid,
    output logic     in_ready,
    output sha_out_t out_data,
    output logic     out_valid,
    input  logic     out_ready
);
    sha_cmd_t    cmd;
    sha_stat_t   stat;
    logic [31:0] word;
    logic [2:0]  idx;

    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .stat      (stat),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_index (idx)
    );

    sha_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (in_data.data_byte),
        .stat      (stat),
        .out_word  (word)
    );

    assign out_data.digest_word = word;
    assign out_data.word_index  = idx;
    assign out_data.last_word   = (idx == 3'd7);
endmodule

[test/testbench.sv]
// Testbench for the SHA-256 byte stream hasher: random byte streams against a local predictor.
`timescale 1ns / 1ps

module testbench
    import sha_pkg::*;
();

    localparam int STALL_LIMIT = 20000;

    logic     clk;
    logic     rst_n;
    sha_in_t  in_data;
    logic     in_valid;
    logic     in_ready;
    sha_out_t out_data;
    logic     out_valid;
    logic     out_ready;

    sha_in_t  pending_items[$];
    sha_out_t digest_words[$];

    logic [31:0] hash_state[8];
    logic [7:0]  block_bytes[64];
    int          fill;
    logic [63:0] bit_count;

    int errors;
    int idle_wait;
    int ready_wait;
    int stall_cycles;
    int items_sent;
    int messages_done;
    int words_seen;

    sha256_byte_stream_hasher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress_buffer();
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int k = 0; k < 16; k++)
            w[k] = {block_bytes[4*k], block_bytes[4*k+1], block_bytes[4*k+2],
                    block_bytes[4*k+3]};
        for (int k = 16; k < 64; k++)
            w[k] = w[k-16] + w[k-7]
                 + (rotr(w[k-15], 7) ^ rotr(w[k-15], 18) ^ (w[k-15] >> 3))
                 + (rotr(w[k-2], 17) ^ rotr(w[k-2], 19) ^ (w[k-2] >> 10));
        for (int k = 0; k < 8; k++)
            v[k] = hash_state[k];
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++)
            hash_state[k] += v[k];
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        block_bytes[fill] = b;
        fill++;
        if (fill == 64)
        begin
            compress_buffer();
            fill = 0;
        end
    endtask

    task automatic predict_digest(input sha_in_t item);
        sha_out_t word;
        if (item.has_byte)
        begin
            absorb_byte(item.data_byte);
            bit_count += 64'd8;
        end
        if (item.end_of_message)
        begin
            absorb_byte(PAD_BYTE);
            while (fill != 56)
                absorb_byte(8'h00);
            for (int k = 0; k < 8; k++)
                absorb_byte(bit_count[63 - 8*k -: 8]);
            for (int k = 0; k < 8; k++)
            begin
                word.digest_word = hash_state[k];
                word.word_index  = 3'(k);
                word.last_word   = (k == 7);
                digest_words = {digest_words, word};
            end
            for (int k = 0; k < 8; k++)
                hash_state[k] = INIT_HASH[k];
            bit_count = '0;
            messages_done++;
        end
    endtask

    task automatic queue_item(input logic [7:0] b, input bit has, input bit last);
        sha_in_t item;
        item.data_byte      = b;
        item.has_byte       = has;
        item.end_of_message = last;
        pending_items = {pending_items, item};
    endtask

    task automatic queue_message(input int len, input int gap_pct);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(99) < gap_pct)
                queue_item(8'($urandom), 1'b0, 1'b0);
            queue_item(8'($urandom), 1'b1, (k == len - 1) && $urandom_range(1));
            if (pending_items[$].end_of_message)
                return;
        end
        queue_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            idle_wait <= 0;
        end
        else if (in_valid && !in_ready)
        begin
        end
        else if (idle_wait > 0)
        begin
            in_valid  <= 1'b0;
            idle_wait <= idle_wait - 1;
        end
        else if (pending_items.size() > 0)
        begin
            in_data   <= pending_items.pop_front();
            in_valid  <= 1'b1;
            idle_wait <= ($urandom_range(3) == 0) ? 0 : $urandom_range(4);
        end
        else
            in_valid <= 1'b0;
    end

    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
        begin
            predict_digest(in_data);
            items_sent++;
        end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_wait <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                words_seen++;
                if (digest_words.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    sha_out_t want;
                    want = digest_words.pop_front();
                    if (want.digest_word != out_data.digest_word)
                    begin
                        $display("%0t: digest_word expected %h actual %h", $time,
                                 want.digest_word, out_data.digest_word);
                        errors++;
                    end
                    if (want.word_index != out_data.word_index)
                    begin
                        $display("%0t: word_index expected %0d actual %0d", $time,
                                 want.word_index, out_data.word_index);
                        errors++;
                    end
                    if (want.last_word != out_data.last_word)
                    begin
                        $display("%0t: last_word expected %b actual %b", $time,
                                 want.last_word, out_data.last_word);
                        errors++;
                    end
                end
            end
            if (ready_wait > 0)
            begin
                out_ready  <= 1'b0;
                ready_wait <= ready_wait - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    ready_wait <= ($urandom_range(3) == 0) ? 0 : $urandom_range(4);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        errors        = 0;
        items_sent    = 0;
        messages_done = 0;
        words_seen    = 0;
        stall_cycles  = 0;
        fill          = 0;
        bit_count     = '0;
        for (int k = 0; k < 8; k++)
            hash_state[k] = INIT_HASH[k];
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle item, empty message, edge bytes, block boundaries
        queue_item(8'hff, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item(8'h00, 1'b1, 1'b1);
        queue_item(8'hff, 1'b1, 1'b1);
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);
        queue_item(8'h55, 1'b0, 1'b1);
        for (int k = 0; k < 55; k++)
            queue_item(8'($urandom), 1'b1, k == 54);
        for (int k = 0; k < 56; k++)
            queue_item(8'($urandom), 1'b1, k == 55);
        for (int k = 0; k < 64; k++)
            queue_item(8'($urandom), 1'b1, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1);

        // random messages, mostly short, some across block boundaries
        while (pending_items.size() < 330)
        begin
            if ($urandom_range(9) == 0)
                queue_message($urandom_range(50, 130), 10);
            else
                queue_message($urandom_range(0, 12), 20);
        end

        wait (pending_items.size() == 0 && !in_valid);
        wait (digest_words.size() == 0);
        repeat (200) @(posedge clk);
        $display("Sent %0d items forming %0d messages; checked %0d digest words.",
                 items_sent, messages_done, words_seen);
        if (errors == 0 && digest_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
